/* hw/rtl/fqclip_pkg.sv */
// Shared constants, types and helpers of the floor quad clip and projection unit.
package fqclip_pkg;

   localparam int MaxVertsDefault    = 8;
   localparam int MaxScreenDimDefault = 4096;
   localparam logic [31:0] OneFix    = 32'd65536;
   localparam logic [31:0] HalfFix   = 32'd32768;

   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_FOV_Y_SLOPE   = 2'd2;
   localparam logic [1:0] CSR_VIEW_SHEAR    = 2'd3;

   // Datapath operation codes issued by the controller.
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;  // write input corners, compute h
   localparam logic [3:0] OP_RD_FIRST  = 4'd2;  // read vertex 0 of source bank
   localparam logic [3:0] OP_PLANE0    = 4'd3;  // plane value of vertex 0 -> d
   localparam logic [3:0] OP_RD_NEXT   = 4'd4;  // read vertices i and j
   localparam logic [3:0] OP_PLANE_J   = 4'd5;  // plane value of vertex j -> dn
   localparam logic [3:0] OP_EMIT_IN   = 4'd6;  // write vertex i to dest bank
   localparam logic [3:0] OP_ISECT     = 4'd7;  // compute intersection, write
   localparam logic [3:0] OP_ADVANCE   = 4'd8;  // d <= dn
   localparam logic [3:0] OP_RD_OUT    = 4'd9;  // read output vertex i of source bank
   localparam logic [3:0] OP_PROJECT   = 4'd10; // projection to result word

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] stage;
      logic       src_bank;
      logic [4:0] idx_i;
      logic [4:0] idx_j;
      logic [4:0] idx_out;
   } fq_cmd_type;

   typedef struct packed {
      logic busy;
      logic d_inside;
      logic sign_change;
      logic rsp_valid;
   } fq_status_type;

   function automatic logic [31:0] fmul32(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
      logic signed [63:0] p;
      begin
         p = 64'(a) * 64'(b);
         fmul32 = p[47:16];  // arithmetic shift = floor
      end
   endfunction

   // Sign-extended 16.16 dividend: a * 65536 as a 64-bit value.
   function automatic logic signed [63:0] fix_scale(input logic [31:0] a);
      begin
         fix_scale = {{16{a[31]}}, a, 16'd0};
      end
   endfunction

endpackage

/* hw/rtl/floor_quad_frustum_clip_project_unit.sv */
// Each intersection runs the iterative divider once, twice in clip stage 2, and
// each projected vertex runs it twice.
// Throughput: one quad at a time; the next input word is taken only after the last
// result word of the current quad has been taken. Reset: synchronous, active high;
// clears control state and restores the register defaults (640 x 480, slope 1.5).
module floor_quad_frustum_clip_project_unit
   import fqclip_pkg::*;
#(
   parameter int MaxVerts     = MaxVertsDefault,
   parameter int MaxScreenDim = MaxScreenDimDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // corner0_x, corner0_z, corner1_x, corner1_z, corner2_x, corner2_z,
   // corner3_x, corner3_z, height_offset (from bit 0 up)
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // screen_x [27:0], screen_y [55:28]
   output logic [55:0]  rsp_tdata,
   output logic         rsp_tlast,
   // culled
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   // The register holds 13 bits, so a limit above 8191 never bites.
   localparam logic [12:0] DimMax = (MaxScreenDim > 8191) ? 13'd8191
                                                          : 13'(MaxScreenDim);

   logic [12:0] scr_w_ff, scr_w_in, scr_h_ff, scr_h_in, dim;
   logic [30:0] fov_ff, fov_in;
   logic signed [13:0] shear_ff, shear_in;
   logic [287:0] req_ff;
   logic        idle, cmd_go, last_out, cull_go;
   fq_cmd_type  cmd;
   fq_status_type status;
   logic [63:0] dp_data;
   logic        req_take;

   assign req_tready = idle;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Saturate the low 13 bits of dimension writes into 1..DimMax.
   always_comb begin
      dim = csr_data[12:0];
      if (dim == 13'd0) dim = 13'd1;
      if (dim > DimMax) dim = DimMax;
      scr_w_in = scr_w_ff; scr_h_in = scr_h_ff; fov_in = fov_ff; shear_in = shear_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  scr_w_in = dim;
            CSR_SCREEN_HEIGHT: scr_h_in = dim;
            CSR_FOV_Y_SLOPE:   fov_in   = csr_data[30:0];
            CSR_VIEW_SHEAR:    shear_in = csr_data[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= 13'd640; scr_h_ff <= 13'd480;
         fov_ff <= 31'd98304; shear_ff <= '0;
      end else begin
         scr_w_ff <= scr_w_in; scr_h_ff <= scr_h_in;
         fov_ff <= fov_in; shear_ff <= shear_in;
      end
      if (req_take) req_ff <= req_tdata;
   end

   fqclip_ctrl #(.MaxVerts(MaxVerts)) u_ctrl (
      .clock, .reset, .req_take, .idle, .status, .cmd, .cmd_go,
      .last_out, .cull_go);

   fqclip_datapath #(.MaxVerts(MaxVerts)) u_dp (
      .clock, .reset, .cmd, .cmd_go, .last_out, .status,
      .req_tdata(req_ff), .scr_w(scr_w_ff), .scr_h(scr_h_ff),
      .fov(fov_ff), .shear(shear_ff), .rsp_tdata(dp_data),
      .rsp_tlast, .rsp_tuser, .rsp_take(rsp_tvalid && rsp_tready),
      .cull_go);

   // Drop the datapath's fill nibbles so screen_y sits right above screen_x.
   assign rsp_tvalid = status.rsp_valid;
   assign rsp_tdata  = {dp_data[59:32], dp_data[27:0]};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken during output");
   a_cull_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast) else $error("culled word not last");
   a_cull_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0)) else $error("culled data");
endmodule

/* hw/rtl/fqclip_ram.sv */
// Generic single-write RAM with registered read.
module fqclip_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

/* hw/rtl/fqclip_div.sv */
// Iterative signed 64/32 divider, one quotient bit per cycle.
module fqclip_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic [31:0]        quot
);
   logic [63:0] rem_ff, rem_in, q_ff, q_in;
   logic [31:0] d_ff, d_in;
   logic        neg_ff, neg_in, run_ff, run_in, done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [64:0] trial;
   logic [63:0] qn;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; d_in = d_ff; neg_in = neg_ff;
      run_in = run_ff; cnt_in = cnt_ff; done_in = 1'b0;
      trial = '0;
      if (start) begin
         rem_in = '0;
         q_in   = num[63] ? 64'(-num) : 64'(num);
         d_in   = den[31] ? 32'(-den) : 32'(den);
         if (den == 32'sd0) d_in = 32'd1;
         neg_in = num[63] ^ (den[31] && den != 32'sd0);
         run_in = 1'b1;
         cnt_in = 7'd0;
      end else if (run_ff) begin
         trial = {rem_ff, q_ff[63]} - {33'd0, d_ff};
         if (!trial[64]) begin
            rem_in = trial[63:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], q_ff[63]};
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; q_ff <= q_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   assign qn   = neg_ff ? 64'(-q_ff) : q_ff;
   assign quot = qn[31:0];
   assign done = done_ff;
endmodule

/* hw/rtl/fqclip_datapath.sv */
// Datapath: vertex banks, plane evaluation, intersection and projection.
module fqclip_datapath
   import fqclip_pkg::*;
#(
   parameter int MaxVerts = MaxVertsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  fq_cmd_type         cmd,
   input  logic               cmd_go,
   input  logic               last_out,
   output fq_status_type      status,
   input  logic [287:0]       req_tdata,
   input  logic [12:0]        scr_w,
   input  logic [12:0]        scr_h,
   input  logic [30:0]        fov,
   input  logic signed [13:0] shear,
   output logic [63:0]        rsp_tdata,
   output logic               rsp_tlast,
   output logic               rsp_tuser,
   input  logic               rsp_take,
   input  logic               cull_go
);
   localparam int AW = $clog2(2 * MaxVerts);

   // Sequencing inside one command: simple sub-step counter for multi-step ops.
   logic [3:0]  sub_ff, sub_in;
   logic        busy_ff, busy_in;
   logic signed [31:0] d_ff, d_in, dn_ff, dn_in, h_ff, h_in;
   logic signed [31:0] xi_ff, xi_in, zi_ff, zi_in, xj_ff, xj_in, zj_ff, zj_in;
   logic signed [31:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [63:0] rsp_ff, rsp_in;
   logic        rv_ff, rv_in, rl_ff, rl_in, rc_ff, rc_in;
   logic        stage2_ff, stage2_in;

   logic        we;
   logic [AW-1:0] waddr, raddr;
   logic [31:0] wx, wz, rx, rz;

   logic        div_start, div_done;
   logic signed [63:0] div_num;
   logic signed [31:0] div_den;
   logic [31:0] div_q;

   logic signed [31:0] mid2, mid2t, midp, pmul, hi_w, hi_h, sx, sy;
   logic signed [31:0] cx, cz;
   logic [AW-1:0] bank_off_src, bank_off_dst;

   fqclip_ram #(.Width(32), .Depth(2 * MaxVerts)) u_ram_x (
      .clock, .we, .waddr, .wdata(wx), .raddr, .rdata(rx));
   fqclip_ram #(.Width(32), .Depth(2 * MaxVerts)) u_ram_z (
      .clock, .we, .waddr, .wdata(wz), .raddr, .rdata(rz));
   fqclip_div u_div (
      .clock, .reset, .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_q));

   assign mid2  = 32'(scr_h >> 1) - 32'(shear);
   assign mid2t = mid2 - 32'(scr_h);
   assign midp  = 32'(scr_h >> 1) + 32'(shear);
   assign hi_w  = {3'd0, scr_w, 16'd0} - 32'sd1;
   assign hi_h  = {3'd0, scr_h, 16'd0} - 32'sd1;
   assign bank_off_src = cmd.src_bank ? AW'(MaxVerts) : '0;
   assign bank_off_dst = cmd.src_bank ? '0 : AW'(MaxVerts);

   always_comb begin
      sub_in = sub_ff; busy_in = busy_ff;
      d_in = d_ff; dn_in = dn_ff; h_in = h_ff;
      xi_in = xi_ff; zi_in = zi_ff; xj_in = xj_ff; zj_in = zj_ff;
      t0_in = t0_ff; t1_in = t1_ff;
      rsp_in = rsp_ff; rv_in = rv_ff; rl_in = rl_ff; rc_in = rc_ff;
      stage2_in = stage2_ff;
      we = 1'b0; waddr = '0; wx = '0; wz = '0; raddr = '0;
      div_start = 1'b0; div_num = '0; div_den = 32'sd1;
      pmul = '0; sx = '0; sy = '0; cx = '0; cz = '0;
      if (rv_ff && rsp_take) rv_in = 1'b0;
      if (cull_go) begin
         rsp_in = '0; rv_in = 1'b1; rl_in = 1'b1; rc_in = 1'b1;
      end
      if (cmd_go) begin
         busy_in = 1'b1; sub_in = '0;
      end else if (busy_ff) begin
         sub_in = sub_ff + 4'd1;
         case (cmd.op)
            OP_LOAD: begin
               we    = 1'b1;
               waddr = AW'(sub_ff[1:0]);
               wx    = req_tdata[64*sub_ff[1:0] +: 32];
               wz    = req_tdata[64*sub_ff[1:0]+32 +: 32];
               if (sub_ff == 4'd3) begin
                  h_in = 32'(req_tdata[287:256]) * 32'(scr_h);
                  busy_in = 1'b0;
               end
            end
            OP_RD_FIRST, OP_RD_OUT: begin
               raddr = bank_off_src + cmd.idx_i[AW-1:0];
               if (sub_ff == 4'd1) begin
                  xi_in = rx; zi_in = rz; busy_in = 1'b0;
               end
            end
            OP_RD_NEXT: begin
               raddr = bank_off_src + (sub_ff == 4'd0 ? cmd.idx_i[AW-1:0]
                                                     : cmd.idx_j[AW-1:0]);
               if (sub_ff == 4'd1) begin
                  xi_in = rx; zi_in = rz;
               end
               if (sub_ff == 4'd2) begin
                  xj_in = rx; zj_in = rz; busy_in = 1'b0;
               end
            end
            OP_PLANE0, OP_PLANE_J: begin
               cx = (cmd.op == OP_PLANE0) ? xi_ff : xj_ff;
               cz = (cmd.op == OP_PLANE0) ? zi_ff : zj_ff;
               if (sub_ff == 4'd0) begin
                  t0_in = fmul32(cz, {1'b0, fov});
               end else begin
                  case (cmd.stage)
                     2'd0: pmul = cx + cz;
                     2'd1: pmul = cx - cz;
                     2'd2: pmul = h_ff + 32'(t0_ff * mid2);
                     default: pmul = h_ff + 32'(t0_ff * mid2t);
                  endcase
                  if (cmd.op == OP_PLANE0) d_in = pmul;
                  else dn_in = pmul;
                  busy_in = 1'b0;
               end
            end
            OP_EMIT_IN: begin
               we = 1'b1; waddr = bank_off_dst + cmd.idx_out[AW-1:0];
               wx = xi_ff; wz = zi_ff; busy_in = 1'b0;
            end
            OP_ISECT: begin
               // Stage 2 divides each fmul(d,delta) by den; others t=d/den first.
               stage2_in = (cmd.stage == 2'd2);
               case (sub_ff)
                  4'd0: begin
                     div_start = 1'b1;
                     if (cmd.stage == 2'd2)
                        div_num = fix_scale(fmul32(d_ff, xj_ff - xi_ff));
                     else
                        div_num = fix_scale(d_ff);
                     div_den = d_ff - dn_ff;
                  end
                  4'd1: begin
                     sub_in = div_done ? 4'd2 : 4'd1;
                     if (div_done) begin
                        if (stage2_ff) t0_in = xi_ff + div_q;
                        else t0_in = xi_ff + fmul32(div_q, xj_ff - xi_ff);
                        t1_in = div_q;
                     end
                  end
                  4'd2: begin
                     if (stage2_ff) begin
                        div_start = 1'b1;
                        div_num = fix_scale(fmul32(d_ff, zj_ff - zi_ff));
                        div_den = d_ff - dn_ff;
                     end else begin
                        t1_in = zi_ff + fmul32(t1_ff, zj_ff - zi_ff);
                        sub_in = 4'd4;
                     end
                  end
                  4'd3: begin
                     sub_in = div_done ? 4'd4 : 4'd3;
                     if (div_done) t1_in = zi_ff + div_q;
                  end
                  default: begin
                     we = 1'b1; waddr = bank_off_dst + cmd.idx_out[AW-1:0];
                     wx = t0_ff; wz = t1_ff; busy_in = 1'b0;
                  end
               endcase
            end
            OP_ADVANCE: begin
               d_in = dn_ff; busy_in = 1'b0;
            end
            OP_PROJECT: begin
               case (sub_ff)
                  4'd0: begin
                     div_start = 1'b1;
                     div_num = fix_scale(32'(xi_ff * 32'(scr_w >> 1)));
                     div_den = zi_ff;
                     t1_in = fmul32(zi_ff, {1'b0, fov});
                  end
                  4'd1: begin
                     sub_in = div_done ? 4'd2 : 4'd1;
                     if (div_done) t0_in = 32'({scr_w, 15'd0}) + div_q;
                  end
                  4'd2: begin
                     div_start = 1'b1;
                     div_num = 64'(h_ff) <<< 16;
                     div_den = t1_ff;
                  end
                  4'd3: begin
                     sub_in = div_done ? 4'd4 : 4'd3;
                     if (div_done) t1_in = (midp <<< 16) - div_q;
                  end
                  default: begin
                     sx = t0_ff; sy = t1_ff;
                     if (sx > hi_w) sx = hi_w;
                     if (sx < 0) sx = '0;
                     if (sy > hi_h) sy = hi_h;
                     if (sy < 0) sy = '0;
                     rsp_in = {4'd0, sy[27:0], 4'd0, sx[27:0]};
                     rv_in = 1'b1; rl_in = last_out; rc_in = 1'b0;
                     busy_in = 1'b0;
                  end
               endcase
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; rv_ff <= 1'b0; sub_ff <= '0; h_ff <= '0;
      end else begin
         busy_ff <= busy_in; rv_ff <= rv_in; sub_ff <= sub_in; h_ff <= h_in;
      end
      d_ff <= d_in; dn_ff <= dn_in;
      xi_ff <= xi_in; zi_ff <= zi_in; xj_ff <= xj_in; zj_ff <= zj_in;
      t0_ff <= t0_in; t1_ff <= t1_in;
      rsp_ff <= rsp_in; rl_ff <= rl_in; rc_ff <= rc_in; stage2_ff <= stage2_in;
   end

   assign status.busy        = busy_ff;
   assign status.d_inside    = (cmd.stage[0] == 1'b0) ? (d_ff >= 0) : (d_ff <= 0);
   assign status.sign_change = d_ff[31] != dn_ff[31];
   assign status.rsp_valid   = rv_ff;
   assign rsp_tdata = rsp_ff;
   assign rsp_tlast = rl_ff;
   assign rsp_tuser = rc_ff;
endmodule

/* hw/rtl/fqclip_ctrl.sv */
// Controller: sequences load, four clip stages and projection.
module fqclip_ctrl
   import fqclip_pkg::*;
#(
   parameter int MaxVerts = MaxVertsDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_take,
   output logic          idle,
   input  fq_status_type status,
   output fq_cmd_type    cmd,
   output logic          cmd_go,
   output logic          last_out,
   output logic          cull_go
);
   localparam logic [2:0] S_IDLE = 3'd0, S_ISSUE = 3'd1, S_WAIT = 3'd2,
                          S_RSP = 3'd3;
   localparam logic [4:0] MaxV = 5'(MaxVerts);

   logic [2:0] st_ff, st_in;
   fq_cmd_type cmd_ff, cmd_in;
   logic [4:0] n_ff, n_in, out_ff, out_in;
   logic       go_in, go_ff, cull_in, cull_ff;

   always_comb begin
      st_in = st_ff; cmd_in = cmd_ff; n_in = n_ff; out_in = out_ff;
      go_in = 1'b0; cull_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in = '0; cmd_in.op = OP_LOAD; n_in = 5'd4;
               go_in = 1'b1; st_in = S_WAIT;
            end
         end
         S_ISSUE: begin
            go_in = 1'b1; st_in = S_WAIT;
         end
         S_WAIT: begin
            if (!go_ff && !status.busy) begin
               st_in = S_ISSUE;
               case (cmd_ff.op)
                  OP_LOAD: begin
                     cmd_in.op = OP_RD_FIRST; cmd_in.idx_i = '0;
                     cmd_in.stage = '0; cmd_in.src_bank = 1'b0; out_in = '0;
                  end
                  OP_RD_FIRST: cmd_in.op = OP_PLANE0;
                  OP_PLANE0, OP_ADVANCE: begin
                     if (cmd_ff.op == OP_ADVANCE) cmd_in.idx_i = cmd_ff.idx_i + 5'd1;
                     if (cmd_ff.op == OP_ADVANCE && cmd_ff.idx_i + 5'd1 == n_ff) begin
                        // stage done
                        n_in = out_ff;
                        if (out_ff <= 5'd2) begin
                           cull_in = 1'b1; st_in = S_RSP;
                        end else if (cmd_ff.stage == 2'd3) begin
                           cmd_in.op = OP_RD_OUT; cmd_in.idx_i = '0;
                           cmd_in.src_bank = ~cmd_ff.src_bank;
                        end else begin
                           cmd_in.op = OP_RD_FIRST; cmd_in.idx_i = '0;
                           cmd_in.stage = cmd_ff.stage + 2'd1;
                           cmd_in.src_bank = ~cmd_ff.src_bank; out_in = '0;
                        end
                     end else begin
                        cmd_in.op = OP_RD_NEXT;
                        cmd_in.idx_j = (cmd_in.idx_i + 5'd1 == n_ff) ? '0
                                       : cmd_in.idx_i + 5'd1;
                     end
                  end
                  OP_RD_NEXT: cmd_in.op = OP_PLANE_J;
                  OP_PLANE_J: begin
                     cmd_in.idx_out = out_ff;
                     if (status.d_inside && out_ff < MaxV) cmd_in.op = OP_EMIT_IN;
                     else if (status.sign_change && out_ff < MaxV) cmd_in.op = OP_ISECT;
                     else cmd_in.op = OP_ADVANCE;
                  end
                  OP_EMIT_IN: begin
                     out_in = out_ff + 5'd1; cmd_in.idx_out = out_ff + 5'd1;
                     if (status.sign_change && out_ff + 5'd1 < MaxV)
                        cmd_in.op = OP_ISECT;
                     else cmd_in.op = OP_ADVANCE;
                  end
                  OP_ISECT: begin
                     out_in = out_ff + 5'd1; cmd_in.op = OP_ADVANCE;
                  end
                  OP_RD_OUT: cmd_in.op = OP_PROJECT;
                  OP_PROJECT: st_in = S_RSP;
                  default: st_in = S_IDLE;
               endcase
            end
         end
         S_RSP: begin
            if (!status.rsp_valid && !cull_ff) begin
               if (cmd_ff.op == OP_PROJECT && cmd_ff.idx_i + 5'd1 != n_ff) begin
                  cmd_in.op = OP_RD_OUT; cmd_in.idx_i = cmd_ff.idx_i + 5'd1;
                  st_in = S_ISSUE;
               end else begin
                  st_in = S_IDLE;
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; go_ff <= 1'b0; cull_ff <= 1'b0; cmd_ff <= '0;
         n_ff <= '0; out_ff <= '0;
      end else begin
         st_ff <= st_in; go_ff <= go_in; cull_ff <= cull_in; cmd_ff <= cmd_in;
         n_ff <= n_in; out_ff <= out_in;
      end
   end

   assign idle     = (st_ff == S_IDLE);
   assign cmd      = cmd_ff;
   assign cmd_go   = go_ff;
   assign cull_go  = cull_ff;
   assign last_out = (cmd_ff.idx_i + 5'd1 == n_ff);
endmodule

/* sim/floor_quad_frustum_clip_project_unit_tb.sv */
// Self-checking testbench for the floor quad frustum clip and projection unit.
`timescale 1ns / 1ps

module floor_quad_frustum_clip_project_unit_tb;
   import fqclip_pkg::*;

   localparam int ClipMaxVerts = 8;
   localparam int DimLimit     = 4096;
   localparam int StallLimit   = 200000;

   typedef struct packed {
      logic [27:0] sx;
      logic [27:0] sy;
      logic        culled;
      logic        last;
   } vertex_word_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [55:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_data;

   floor_quad_frustum_clip_project_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Shadow copy of the register file and the vertex banks.
   int           width_px, height_px, fovy, shear;
   int           bank_x [2][ClipMaxVerts];
   int           bank_z [2][ClipMaxVerts];
   int           quad_h;
   vertex_word_t expected_vertices [$];
   int           error_count, mismatch_count, word_count, quad_count, cull_count;
   int           idle_cycles;
   bit           rx_stall_enable, tx_stall_enable, rx_hold_off;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // 16.16 multiply, floor rounding, wrapped to 32 bits.
   function automatic int fx_mul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b);
      return int'(p >>> 16);
   endfunction

   // 16.16 divide, truncating, zero divisor taken as one.
   function automatic int fx_div(int a, int b);
      longint n, d;
      n = longint'(a) * 65536;
      d = (b == 0) ? 1 : b;
      return int'(n / d);
   endfunction

   function automatic int dim_sat(logic [31:0] v);
      int t;
      t = int'(v[12:0]);
      if (t < 1) t = 1;
      if (t > DimLimit) t = DimLimit;
      return t;
   endfunction

   function automatic int plane_of(int stage, int x, int z);
      int mid2;
      mid2 = height_px / 2 - shear;
      case (stage)
         0: return x + z;
         1: return x - z;
         2: return quad_h + fx_mul(z, fovy) * mid2;
         default: return quad_h + fx_mul(z, fovy) * (mid2 - height_px);
      endcase
   endfunction

   function automatic int clip_against(int stage, int src, int n);
      int dst, cnt, j, xi, zi, xj, zj, d, dn, den, t, nx, nz;
      bit keep;
      dst = src ^ 1;
      cnt = 0;
      d = plane_of(stage, bank_x[src][0], bank_z[src][0]);
      for (int i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         xi = bank_x[src][i]; zi = bank_z[src][i];
         xj = bank_x[src][j]; zj = bank_z[src][j];
         dn = plane_of(stage, xj, zj);
         keep = (stage == 0 || stage == 2) ? (d >= 0) : (d <= 0);
         if (keep && cnt < ClipMaxVerts) begin
            bank_x[dst][cnt] = xi;
            bank_z[dst][cnt] = zi;
            cnt++;
         end
         if (((d < 0) != (dn < 0)) && cnt < ClipMaxVerts) begin
            den = d - dn;
            if (den == 0) den = 1;
            if (stage == 2) begin
               nx = xi + fx_div(fx_mul(d, xj - xi), den);
               nz = zi + fx_div(fx_mul(d, zj - zi), den);
            end else begin
               t  = fx_div(d, den);
               nx = xi + fx_mul(t, xj - xi);
               nz = zi + fx_mul(t, zj - zi);
            end
            bank_x[dst][cnt] = nx;
            bank_z[dst][cnt] = nz;
            cnt++;
         end
         d = dn;
      end
      return cnt;
   endfunction

   function automatic int clamp_screen(int v, int dim);
      int hi;
      hi = dim * 65536 - 1;
      if (v > hi) v = hi;
      if (v < 0) v = 0;
      return v;
   endfunction

   // Clip and project one quad; queue its vertex words.
   function automatic void predict_quad(logic [287:0] w);
      int n, bank, mid, x, z, sx, sy, zd, fz;
      vertex_word_t v;
      for (int i = 0; i < 4; i++) begin
         bank_x[0][i] = w[64*i +: 32];
         bank_z[0][i] = w[64*i + 32 +: 32];
      end
      quad_h = int'(w[287:256]) * height_px;
      n = 4;
      bank = 0;
      for (int s = 0; s < 4; s++) begin
         n = clip_against(s, bank, n);
         bank ^= 1;
         if (n <= 2) begin
            v = '0;
            v.culled = 1'b1;
            v.last = 1'b1;
            expected_vertices.push_back(v);
            return;
         end
      end
      mid = height_px / 2 + shear;
      for (int i = 0; i < n; i++) begin
         x = bank_x[bank][i];
         z = bank_z[bank][i];
         zd = (z == 0) ? 1 : z;
         fz = fx_mul(z, fovy);
         if (fz == 0) fz = 1;
         sx = width_px * 32768 + fx_div(x * (width_px / 2), zd);
         sy = mid * 65536 - fx_div(quad_h, fz);
         v.sx = 28'(clamp_screen(sx, width_px));
         v.sy = 28'(clamp_screen(sy, height_px));
         v.culled = 1'b0;
         v.last = (i + 1 == n);
         expected_vertices.push_back(v);
      end
   endfunction

   // Send one quad: drive at the falling edge, hold until accepted.
   task automatic send_quad(logic [287:0] w);
      @(negedge clock);
      if (tx_stall_enable && $urandom_range(3) == 0)
         repeat ($urandom_range(1, 17)) @(negedge clock);
      req_tdata  <= w;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_quad(w);
      quad_count++;
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SCREEN_WIDTH:  width_px  = dim_sat(val);
         CSR_SCREEN_HEIGHT: height_px = dim_sat(val);
         CSR_FOV_Y_SLOPE:   fovy      = int'({1'b0, val[30:0]});
         default:           shear     = int'({{18{val[13]}}, val[13:0]});
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drain outstanding words, then let the block settle before touching registers.
   task automatic wait_drained();
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [287:0] make_quad(int x0, int z0, int x1, int z1,
                                              int x2, int z2, int x3, int z3, int ho);
      return {ho, z3, x3, z2, x2, z1, x1, z0, x0};
   endfunction

   function automatic int rand_word();
      return int'($urandom());
   endfunction

   // A view-facing quad with random size and depth so most words survive clipping.
   function automatic logic [287:0] visible_quad();
      int cz, cx, r, ho;
      cz = $urandom_range(2, 200) * 65536 + $urandom_range(0, 65535);
      cx = int'($urandom_range(0, 2 * cz)) - cz;
      r  = $urandom_range(1, 400) * 65536 + $urandom_range(0, 65535);
      ho = int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
      return make_quad(cx - r, cz - r, cx + r, cz - r, cx + r, cz + r, cx - r, cz + r, ho);
   endfunction

   // Receiver: random back-pressure, one long hold-off, compare each word.
   initial begin
      vertex_word_t got, want;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_off) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(negedge clock);
            rx_hold_off = 1'b0;
         end else if (rx_stall_enable && $urandom_range(4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.sx = rsp_tdata[27:0];
            got.sy = rsp_tdata[55:28];
            got.culled = rsp_tuser;
            got.last = rsp_tlast;
            word_count++;
            if (got.culled) cull_count++;
            if (expected_vertices.size() == 0) begin
               error_count++;
               if (mismatch_count++ < 10)
                  $display("unexpected word sx=%h sy=%h culled=%b last=%b",
                           got.sx, got.sy, got.culled, got.last);
            end else begin
               want = expected_vertices.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (mismatch_count++ < 10)
                     $display("mismatch exp sx=%h sy=%h c=%b l=%b got sx=%h sy=%h c=%b l=%b",
                              want.sx, want.sy, want.culled, want.last,
                              got.sx, got.sy, got.culled, got.last);
               end
            end
         end
      end
   end

   // Watchdog: count cycles with no accepted word on any channel.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else if (++idle_cycles >= StallLimit) begin
            $display("floor_quad_frustum_clip_project_unit_tb NOT OK");
            $finish;
         end
      end
   end

   task automatic test_corner_cases();
      int big, neg;
      big = 32'h7FFFFFFF;
      neg = 32'h80000000;
      send_quad(make_quad(-65536, 131072, 65536, 131072, 65536, 262144, -65536, 262144, 0));
      send_quad(make_quad(big, big, big, big, big, big, big, big, big));
      send_quad(make_quad(neg, neg, neg, neg, neg, neg, neg, neg, neg));
      send_quad(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_quad(make_quad(-1, -1, -1, -1, -1, -1, -1, -1, -1));
      // fully behind the camera: culled
      send_quad(make_quad(-65536, -131072, 65536, -131072, 65536, -262144, -65536, -262144, 0));
      // vertex exactly on the left plane
      send_quad(make_quad(-131072, 131072, 65536, 131072, 65536, 262144, -65536, 262144, 0));
      // wide quad straddling both side planes, many vertices
      send_quad(make_quad(-20*65536, 65536, 20*65536, 65536, 20*65536, 10*65536,
                          -20*65536, 10*65536, 65536));
      // extreme heights against the top and bottom planes
      send_quad(make_quad(-65536, 65536, 65536, 65536, 65536, 30*65536, -65536, 30*65536, big));
      send_quad(make_quad(-65536, 65536, 65536, 65536, 65536, 30*65536, -65536, 30*65536, neg));
      send_quad(make_quad(-4*65536, 2*65536, 4*65536, 2*65536, 4*65536, 40*65536,
                          -4*65536, 40*65536, 3*65536));
      send_quad(make_quad(-4*65536, 2*65536, 4*65536, 2*65536, 4*65536, 40*65536,
                          -4*65536, 40*65536, -3*65536));
      // diamond clipped on all four planes
      send_quad(make_quad(0, 65536, 50*65536, 20*65536, 0, 60*65536, -50*65536, 20*65536, 32768));
      for (int i = 0; i < 6; i++)
         send_quad(make_quad(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                             rand_word(), rand_word(), rand_word(), rand_word()));
   endtask

   task automatic test_register_extremes();
      wait_drained();
      write_reg(CSR_SCREEN_WIDTH, 32'd0);
      write_reg(CSR_SCREEN_HEIGHT, 32'h1FFF);
      write_reg(CSR_FOV_Y_SLOPE, 32'hFFFFFFFF);
      write_reg(CSR_VIEW_SHEAR, 32'h2000);
      for (int i = 0; i < 4; i++) send_quad(visible_quad());
      wait_drained();
      write_reg(CSR_SCREEN_WIDTH, 32'd4096);
      write_reg(CSR_SCREEN_HEIGHT, 32'd1);
      write_reg(CSR_FOV_Y_SLOPE, 32'd1);
      write_reg(CSR_VIEW_SHEAR, 32'h1000);
      for (int i = 0; i < 4; i++) send_quad(visible_quad());
      wait_drained();
      write_reg(CSR_SCREEN_WIDTH, 32'd320);
      write_reg(CSR_SCREEN_HEIGHT, 32'd240);
      write_reg(CSR_FOV_Y_SLOPE, 32'd65536);
      write_reg(CSR_VIEW_SHEAR, 32'h3FF0);
   endtask

   task automatic test_random_quads(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 7)
            send_quad(visible_quad());
         else
            send_quad(make_quad(rand_word(), rand_word(), rand_word(), rand_word(),
                                rand_word(), rand_word(), rand_word(), rand_word(),
                                rand_word()));
      end
   endtask

   // Stall the receiver long while quads keep coming, so the input backs up.
   task automatic test_backpressure();
      rx_hold_off = 1'b1;
      for (int i = 0; i < 4; i++) send_quad(visible_quad());
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SCREEN_WIDTH;
      csr_data = '0;
      rx_stall_enable = 1'b1;
      tx_stall_enable = 1'b1;
      rx_hold_off = 1'b0;
      error_count = 0; mismatch_count = 0;
      word_count = 0; quad_count = 0; cull_count = 0;
      width_px = 640; height_px = 480; fovy = 98304; shear = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corner_cases();
      test_register_extremes();
      test_random_quads(40);
      test_backpressure();
      wait_drained();
      write_reg(CSR_SCREEN_WIDTH, 32'd640);
      write_reg(CSR_SCREEN_HEIGHT, 32'd480);
      write_reg(CSR_FOV_Y_SLOPE, 32'd98304);
      write_reg(CSR_VIEW_SHEAR, 32'd0);
      test_random_quads(40);
      // final stretch with no idling on either side
      rx_stall_enable = 1'b0;
      tx_stall_enable = 1'b0;
      test_random_quads(20);

      wait_drained();
      $display("covered %0d quads, %0d vertex words (%0d culled), several register settings",
               quad_count, word_count, cull_count);
      if (error_count == 0)
         $display("floor_quad_frustum_clip_project_unit_tb OK");
      else
         $display("floor_quad_frustum_clip_project_unit_tb NOT OK");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/fqclip_pkg.sv
hw/rtl/fqclip_ram.sv
hw/rtl/fqclip_div.sv
hw/rtl/fqclip_datapath.sv
hw/rtl/fqclip_ctrl.sv
hw/rtl/floor_quad_frustum_clip_project_unit.sv
sim/floor_quad_frustum_clip_project_unit_tb.sv
